// File: src/lntok_pkg.sv
// ----------------------------------------------------------------------------
// Line tokenizer package
// Shared types and character constants for the line tokenizer block.
// ----------------------------------------------------------------------------
`default_nettype none

package lntok_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [1:0] CLASS_PREFIX   = 2'd0;
    localparam logic [1:0] CLASS_COMMAND  = 2'd1;
    localparam logic [1:0] CLASS_PARAM    = 2'd2;
    localparam logic [1:0] CLASS_TRAILING = 2'd3;

    localparam logic [3:0] PARAM_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_PREFIX     = 3'd1,
        PH_PREFIX_GAP = 3'd2,
        PH_COMMAND    = 3'd3,
        PH_GAP        = 3'd4,
        PH_PARAM      = 3'd5,
        PH_TRAILING   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_FLUSH = 3'd1,
        ST_CR    = 3'd2,
        ST_BYTE  = 3'd3,
        ST_LAST  = 3'd4
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SRC_INPUT = 2'd0,
        SRC_HELD  = 2'd1,
        SRC_CR    = 2'd2,
        SRC_BYTE  = 2'd3
    } tok_src_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] token_class;
        logic       token_start;
        logic [3:0] param_index;
        logic       end_of_line;
        logic       command_present;
        logic       whitespace_overflow;
        logic       last;
    } result_t;

    typedef struct packed {
        logic     use_input;
        logic     tok_en;
        tok_src_t tok_src;
        logic     tok_final;
        logic     side_en;
        logic     clear_cr;
        logic     clear_held;
        logic     latch_byte;
        logic     rd_start;
        logic     rd_issue;
        logic     eol_en;
        logic     last_push;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic cr_held;
        logic held_empty;
        logic flush_last;
        logic need_last;
        logic cur_is_cr;
        logic cur_is_lf;
        logic cur_is_ws;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/irc_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Line tokenizer unit
// Splits a byte stream into CR LF lines, trims trailing blanks and tags
// every content byte with its token class, start flag and parameter index.
// ----------------------------------------------------------------------------
// Latency: a byte that releases nothing gives its result in the cycle after it is taken.
// A byte that releases held blanks or a held CR keeps the controller busy for the
// accept, the held blanks read one by one (single read port of the blank store),
// then, as needed, the CR, the byte and the hand-over of the held-back last result.
// Throughput: one item per cycle while nothing is held and results are taken.
// Reset: synchronous, active low; parse and control state clear, the blank store is not.
`default_nettype none

module irc_line_tokenizer_unit #(
    parameter int MAX_HELD = 62
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // out_byte, token_start, param_index,
                                        // command_present, whitespace_overflow
    output logic      [2:0]  m_tuser,   // token_class, end_of_line
    output logic             m_tlast
);

    import lntok_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lntok_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lntok_datapath #(
        .MAX_HELD (MAX_HELD)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// File: src/lntok_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lntok_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 62,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/lntok_ctrl.sv
// ----------------------------------------------------------------------------
// Line tokenizer controller
// Sequences input acceptance, whitespace flushing and result release.
// ----------------------------------------------------------------------------
`default_nettype none

module lntok_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire lntok_pkg::dp_status_t status,
    output lntok_pkg::dp_cmd_t       cmd
);

    import lntok_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        cr_path_reg, cr_path_next;
    logic        cur_content;

    assign cur_content = !status.cur_is_cr && !status.cur_is_ws;
    assign s_tready    = (state_reg == ST_IDLE) && status.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cr_path_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cr_path_reg <= cr_path_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cr_path_next = cr_path_reg;
        cmd          = '0;
        cmd.tok_src  = SRC_INPUT;
        case (state_reg)
            ST_IDLE: begin
                cmd.use_input = 1'b1;
                if (s_tvalid && status.out_free) begin
                    if (status.cr_held) begin
                        cmd.clear_cr = 1'b1;
                        if (status.cur_is_lf) begin
                            cmd.eol_en = 1'b1;
                        end else begin
                            cmd.latch_byte = 1'b1;
                            cr_path_next   = 1'b1;
                            if (status.held_empty) begin
                                state_next = ST_CR;
                            end else begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_FLUSH;
                            end
                        end
                    end else if (status.cur_is_cr || status.cur_is_ws) begin
                        cmd.side_en = 1'b1;
                    end else if (status.held_empty) begin
                        cmd.tok_en    = 1'b1;
                        cmd.tok_src   = SRC_INPUT;
                        cmd.tok_final = 1'b1;
                    end else begin
                        cmd.latch_byte = 1'b1;
                        cmd.rd_start   = 1'b1;
                        cr_path_next   = 1'b0;
                        state_next     = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.tok_en  = 1'b1;
                    cmd.tok_src = SRC_HELD;
                    if (status.flush_last) begin
                        cmd.clear_held = 1'b1;
                        state_next     = cr_path_reg ? ST_CR : ST_BYTE;
                    end else begin
                        cmd.rd_issue = 1'b1;
                    end
                end
            end
            ST_CR: begin
                if (status.out_free) begin
                    cmd.tok_en    = 1'b1;
                    cmd.tok_src   = SRC_CR;
                    cmd.tok_final = !cur_content;
                    cmd.side_en   = !cur_content;
                    if (status.need_last) begin
                        state_next = ST_LAST;
                    end else if (cur_content) begin
                        state_next = ST_BYTE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BYTE: begin
                if (status.out_free) begin
                    cmd.tok_en    = 1'b1;
                    cmd.tok_src   = SRC_BYTE;
                    cmd.tok_final = 1'b1;
                    state_next    = status.need_last ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST: begin
                if (status.out_free) begin
                    cmd.last_push = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/lntok_datapath.sv
// ----------------------------------------------------------------------------
// Line tokenizer datapath
// Parse state, whitespace store, one-result holdback and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lntok_datapath #(
    parameter int MAX_HELD = 62
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [7:0]            s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,
    output logic      [2:0]            m_tuser,
    output logic                       m_tlast,
    input  wire lntok_pkg::dp_cmd_t    cmd,
    output lntok_pkg::dp_status_t      status
);

    import lntok_pkg::*;

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam logic [CW-1:0] HELD_LIMIT = CW'(MAX_HELD);

    phase_t        phase_reg, phase_next;
    logic [3:0]    param_reg, param_next;
    logic          fresh_reg, fresh_next;
    logic          cmd_seen_reg, cmd_seen_next;
    logic          ovf_reg;
    logic          cr_held_reg;
    logic [CW-1:0] held_count_reg;
    logic [CW-1:0] idx_reg;
    logic [7:0]    byte_reg;
    logic          pend_valid_reg, pend_valid_next;
    result_t       pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          out_free;
    logic          out_load;
    logic [7:0]    cur_byte;
    logic [7:0]    tok_byte;
    logic          cur_is_cr, cur_is_ws;
    logic          held_bit;
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic          tk_has;
    result_t       tk_res;
    result_t       eol_res;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || m_tready;
    assign cur_byte  = cmd.use_input ? s_tdata : byte_reg;
    assign cur_is_cr = (cur_byte == CHAR_CR);
    assign cur_is_ws = (cur_byte == CHAR_SPACE) || (cur_byte == CHAR_TAB);

    assign ram_wr_en   = cmd.side_en && cur_is_ws && (held_count_reg < HELD_LIMIT);
    assign ram_rd_en   = cmd.rd_start || cmd.rd_issue;
    assign ram_rd_addr = cmd.rd_start ? '0 : idx_reg[AW-1:0];

    lntok_ram #(
        .WIDTH (1),
        .DEPTH (MAX_HELD),
        .AW    (AW)
    ) u_held_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (held_count_reg[AW-1:0]),
        .wr_data (cur_byte == CHAR_TAB),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (held_bit)
    );

    always_comb begin
        case (cmd.tok_src)
            SRC_INPUT: tok_byte = s_tdata;
            SRC_HELD:  tok_byte = held_bit ? CHAR_TAB : CHAR_SPACE;
            SRC_CR:    tok_byte = CHAR_CR;
            SRC_BYTE:  tok_byte = byte_reg;
            default:   tok_byte = byte_reg;
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        param_next    = param_reg;
        fresh_next    = fresh_reg;
        cmd_seen_next = cmd_seen_reg;
        tk_has        = 1'b0;
        tk_res        = '0;
        tk_res.out_byte = tok_byte;
        case (phase_reg)
            PH_PREFIX: begin
                if (tok_byte == CHAR_SPACE) begin
                    phase_next = PH_PREFIX_GAP;
                end else begin
                    tk_has             = 1'b1;
                    tk_res.token_class = CLASS_PREFIX;
                    tk_res.token_start = fresh_reg;
                    fresh_next         = 1'b0;
                end
            end
            PH_PREFIX_GAP: begin
                if (tok_byte != CHAR_SPACE) begin
                    phase_next         = PH_COMMAND;
                    cmd_seen_next      = 1'b1;
                    tk_has             = 1'b1;
                    tk_res.out_byte    = to_upper(tok_byte);
                    tk_res.token_class = CLASS_COMMAND;
                    tk_res.token_start = 1'b1;
                end
            end
            PH_COMMAND: begin
                if (tok_byte == CHAR_SPACE) begin
                    phase_next = PH_GAP;
                end else begin
                    tk_has             = 1'b1;
                    tk_res.out_byte    = to_upper(tok_byte);
                    tk_res.token_class = CLASS_COMMAND;
                end
            end
            PH_GAP: begin
                if (tok_byte == CHAR_COLON) begin
                    phase_next = PH_TRAILING;
                    fresh_next = 1'b1;
                end else if (tok_byte != CHAR_SPACE) begin
                    phase_next         = PH_PARAM;
                    tk_has             = 1'b1;
                    tk_res.token_class = CLASS_PARAM;
                    tk_res.token_start = 1'b1;
                    tk_res.param_index = param_reg;
                end
            end
            PH_PARAM: begin
                if (tok_byte == CHAR_SPACE) begin
                    phase_next = PH_GAP;
                    if (param_reg != PARAM_MAX) begin
                        param_next = param_reg + 4'd1;
                    end
                end else begin
                    tk_has             = 1'b1;
                    tk_res.token_class = CLASS_PARAM;
                    tk_res.param_index = param_reg;
                end
            end
            PH_TRAILING: begin
                tk_has             = 1'b1;
                tk_res.token_class = CLASS_TRAILING;
                tk_res.token_start = fresh_reg;
                tk_res.param_index = param_reg;
                fresh_next         = 1'b0;
            end
            default: begin
                if (tok_byte == CHAR_COLON) begin
                    phase_next = PH_PREFIX;
                    fresh_next = 1'b1;
                end else if (tok_byte == CHAR_SPACE) begin
                    phase_next = PH_GAP;
                end else begin
                    phase_next         = PH_COMMAND;
                    cmd_seen_next      = 1'b1;
                    tk_has             = 1'b1;
                    tk_res.out_byte    = to_upper(tok_byte);
                    tk_res.token_class = CLASS_COMMAND;
                    tk_res.token_start = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        eol_res                     = '0;
        eol_res.end_of_line         = 1'b1;
        eol_res.command_present     = cmd_seen_reg;
        eol_res.whitespace_overflow = ovf_reg;
        eol_res.last                = 1'b1;
    end

    // A produced result waits in the holdback slot until it is known
    // whether another result of the same item follows it.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_next        = out_reg;
        if (cmd.eol_en) begin
            out_load = 1'b1;
            out_next = eol_res;
        end else if (cmd.last_push) begin
            out_load        = 1'b1;
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end else if (cmd.tok_en) begin
            if (tk_has) begin
                if (pend_valid_reg) begin
                    out_load  = 1'b1;
                    out_next  = pend_reg;
                    pend_next = tk_res;
                end else if (cmd.tok_final) begin
                    out_load      = 1'b1;
                    out_next      = tk_res;
                    out_next.last = 1'b1;
                end else begin
                    pend_next       = tk_res;
                    pend_valid_next = 1'b1;
                end
            end else if (cmd.tok_final && pend_valid_reg) begin
                out_load        = 1'b1;
                out_next        = pend_reg;
                out_next.last   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LINE_START;
            param_reg      <= '0;
            fresh_reg      <= 1'b0;
            cmd_seen_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            cr_held_reg    <= 1'b0;
            held_count_reg <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.eol_en) begin
                phase_reg      <= PH_LINE_START;
                param_reg      <= '0;
                fresh_reg      <= 1'b0;
                cmd_seen_reg   <= 1'b0;
                ovf_reg        <= 1'b0;
                held_count_reg <= '0;
            end else if (cmd.tok_en) begin
                phase_reg    <= phase_next;
                param_reg    <= param_next;
                fresh_reg    <= fresh_next;
                cmd_seen_reg <= cmd_seen_next;
            end
            if (cmd.clear_cr) begin
                cr_held_reg <= 1'b0;
            end
            if (cmd.clear_held) begin
                held_count_reg <= '0;
            end
            if (cmd.side_en && cur_is_cr) begin
                cr_held_reg <= 1'b1;
            end
            if (ram_wr_en) begin
                held_count_reg <= held_count_reg + 1'b1;
            end else if (cmd.side_en && cur_is_ws) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.rd_start) begin
                idx_reg <= CW'(1);
            end else if (cmd.rd_issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_byte) begin
            byte_reg <= s_tdata;
        end
        pend_reg <= pend_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign status.out_free   = out_free;
    assign status.cr_held    = cr_held_reg;
    assign status.held_empty = (held_count_reg == '0);
    assign status.flush_last = (idx_reg == held_count_reg);
    assign status.need_last  = cmd.tok_en && cmd.tok_final && tk_has && pend_valid_reg;
    assign status.cur_is_cr  = cur_is_cr;
    assign status.cur_is_lf  = (cur_byte == CHAR_LF);
    assign status.cur_is_ws  = cur_is_ws;

    assign m_tvalid = out_valid_reg;
    // m_tdata: out_byte, token_start, param_index, command_present,
    // whitespace_overflow, one zero bit.
    assign m_tdata  = {1'b0, out_reg.whitespace_overflow, out_reg.command_present,
                       out_reg.param_index, out_reg.token_start, out_reg.out_byte};
    // m_tuser: token_class, end_of_line.
    assign m_tuser  = {out_reg.end_of_line, out_reg.token_class};
    assign m_tlast  = out_reg.last;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("Output register loaded while a result is still waiting.");

    a_eol_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eol_en |-> !pend_valid_reg)
        else $error("Line end issued with a result still held back.");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= HELD_LIMIT)
        else $error("Held whitespace count beyond store size.");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (idx_reg < held_count_reg))
        else $error("Whitespace store read past its fill level.");

endmodule

`default_nettype wire

// File: sim/irc_line_tokenizer_unit_checker.sv
// ----------------------------------------------------------------------------
// Line tokenizer result checker
// Watches both stream channels of the line tokenizer, predicts the tagged
// bytes and line-end items that each accepted input byte causes, and
// compares every accepted result field by field against the oldest
// prediction. It reports the number of failures and the results still owed.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_unit_checker #(
    parameter int HELD_DEPTH = 62
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // out_byte, token_start, param_index,
                                        // command_present, whitespace_overflow
    input  wire logic [2:0]  m_tuser,   // token_class, end_of_line
    input  wire logic        m_tlast,
    output int               mismatch_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lntok_pkg::*;

    result_t    token_q [$];
    phase_t     line_phase;
    logic [3:0] param_no;
    logic       held_is_tab [HELD_DEPTH];
    int         held_count;
    logic       cr_waiting;
    logic       saw_command;
    logic       saw_overflow;
    logic       token_first;
    int         emitted;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'h20 : b;
    endfunction

    function automatic void push_token(input logic [7:0] b, input logic [1:0] cls,
                                       input logic first, input logic [3:0] idx);
        result_t r;
        r             = '0;
        r.out_byte    = b;
        r.token_class = cls;
        r.token_start = first;
        r.param_index = idx;
        token_q.insert(token_q.size(), r);
        emitted++;
    endfunction

    function automatic void start_line();
        line_phase   = PH_LINE_START;
        param_no     = '0;
        held_count   = 0;
        saw_command  = 1'b0;
        saw_overflow = 1'b0;
        token_first  = 1'b0;
    endfunction

    function automatic void advance_parser(input logic [7:0] b);
        case (line_phase)
            PH_PREFIX: begin
                if (b == CHAR_SPACE) begin
                    line_phase = PH_PREFIX_GAP;
                end else begin
                    push_token(b, CLASS_PREFIX, token_first, '0);
                    token_first = 1'b0;
                end
            end
            PH_PREFIX_GAP: begin
                if (b != CHAR_SPACE) begin
                    line_phase  = PH_COMMAND;
                    saw_command = 1'b1;
                    push_token(upcase(b), CLASS_COMMAND, 1'b1, '0);
                end
            end
            PH_COMMAND: begin
                if (b == CHAR_SPACE) begin
                    line_phase = PH_GAP;
                end else begin
                    push_token(upcase(b), CLASS_COMMAND, 1'b0, '0);
                end
            end
            PH_GAP: begin
                if (b == CHAR_COLON) begin
                    line_phase  = PH_TRAILING;
                    token_first = 1'b1;
                end else if (b != CHAR_SPACE) begin
                    line_phase = PH_PARAM;
                    push_token(b, CLASS_PARAM, 1'b1, param_no);
                end
            end
            PH_PARAM: begin
                if (b == CHAR_SPACE) begin
                    line_phase = PH_GAP;
                    if (param_no != PARAM_MAX) begin
                        param_no++;
                    end
                end else begin
                    push_token(b, CLASS_PARAM, 1'b0, param_no);
                end
            end
            PH_TRAILING: begin
                push_token(b, CLASS_TRAILING, token_first, param_no);
                token_first = 1'b0;
            end
            default: begin
                if (b == CHAR_COLON) begin
                    line_phase  = PH_PREFIX;
                    token_first = 1'b1;
                end else if (b == CHAR_SPACE) begin
                    line_phase = PH_GAP;
                end else begin
                    line_phase  = PH_COMMAND;
                    saw_command = 1'b1;
                    push_token(upcase(b), CLASS_COMMAND, 1'b1, '0);
                end
            end
        endcase
    endfunction

    function automatic void release_blanks();
        for (int i = 0; i < held_count; i++) begin
            advance_parser(held_is_tab[i] ? CHAR_TAB : CHAR_SPACE);
        end
        held_count = 0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        result_t r;
        emitted = 0;
        if (cr_waiting) begin
            cr_waiting = 1'b0;
            if (b == CHAR_LF) begin
                r                     = '0;
                r.end_of_line         = 1'b1;
                r.command_present     = saw_command;
                r.whitespace_overflow = saw_overflow;
                r.last                = 1'b1;
                token_q.insert(token_q.size(), r);
                start_line();
                return;
            end
            release_blanks();
            advance_parser(CHAR_CR);
        end
        if (b == CHAR_CR) begin
            cr_waiting = 1'b1;
        end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
            if (held_count < HELD_DEPTH) begin
                held_is_tab[held_count] = (b == CHAR_TAB);
                held_count++;
            end else begin
                saw_overflow = 1'b1;
            end
        end else begin
            release_blanks();
            advance_parser(b);
        end
        if (emitted > 0) begin
            r      = token_q.pop_back();
            r.last = 1'b1;
            token_q.insert(token_q.size(), r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            start_line();
            cr_waiting = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    $display({"%0t: unexpected item, expected none, ",
                              "actual tdata %h tuser %h tlast %b"},
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end else begin
                    e = token_q.pop_front();
                    check_field("out_byte", e.out_byte, m_tdata[7:0]);
                    check_field("token_start", e.token_start, m_tdata[8]);
                    check_field("param_index", e.param_index, m_tdata[12:9]);
                    check_field("command_present", e.command_present, m_tdata[13]);
                    check_field("whitespace_overflow", e.whitespace_overflow, m_tdata[14]);
                    check_field("tdata padding", '0, m_tdata[15]);
                    check_field("token_class", e.token_class, m_tuser[1:0]);
                    check_field("end_of_line", e.end_of_line, m_tuser[2]);
                    check_field("last", e.last, m_tlast);
                end
            end
        end
        outstanding = token_q.size();
    end

endmodule

// File: sim/irc_line_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// Line tokenizer testbench
// Drives short directed lines and then random well-formed, broken and noise
// lines into the line tokenizer with random gaps on both channels, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lntok_pkg::*;

    localparam int HELD_DEPTH = 62;

    typedef enum int {
        LINE_FORMED,
        LINE_MANY_PARAMS,
        LINE_OVERFLOW,
        LINE_NOISE,
        LINE_BROKEN
    } line_kind_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;
    int          mismatch_total;
    int          pending_results;
    logic        no_idle = 1'b0;
    logic [7:0]  line_q [$];

    irc_line_tokenizer_unit #(
        .MAX_HELD(HELD_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    irc_line_tokenizer_unit_checker #(
        .HELD_DEPTH(HELD_DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_total),
        .outstanding   (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void put_byte(input logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endfunction

    function automatic logic [7:0] pick_content();
        logic [7:0] b;
        logic [7:0] edges [12] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h40, 8'h41,
                                   8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
        do begin
            case ($urandom_range(0, 3))
                0: b = edges[$urandom_range(0, 11)];
                1: b = 8'($urandom_range("a", "z"));
                default: b = 8'($urandom_range(0, 255));
            endcase
        end while (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR ||
                   b == CHAR_LF || b == CHAR_COLON);
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 3) == 0) ? CHAR_TAB : CHAR_SPACE;
    endfunction

    function automatic void add_word(input int n);
        repeat (n) put_byte(pick_content());
    endfunction

    function automatic void build_line(input line_kind_t kind);
        int nparams;
        line_q.delete();
        if (kind == LINE_NOISE) begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0: put_byte(CHAR_CR);
                    1: put_byte(CHAR_LF);
                    default: put_byte(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        if (kind == LINE_OVERFLOW) begin
            add_word(2);
            repeat (HELD_DEPTH + $urandom_range(1, 4)) put_byte(pick_blank());
            add_word(1);
            repeat ($urandom_range(0, 3)) put_byte(pick_blank());
            put_byte(CHAR_CR);
            put_byte(CHAR_LF);
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            put_byte(CHAR_COLON);
            add_word($urandom_range(0, 4));
            put_byte(CHAR_SPACE);
        end else if ($urandom_range(0, 7) == 0) begin
            put_byte(CHAR_SPACE);
        end
        add_word($urandom_range(0, 5));
        nparams = (kind == LINE_MANY_PARAMS) ? $urandom_range(16, 19) : $urandom_range(0, 3);
        repeat (nparams) begin
            repeat ($urandom_range(1, 2)) put_byte(pick_blank());
            add_word((kind == LINE_MANY_PARAMS) ? 1 : $urandom_range(1, 4));
        end
        if ($urandom_range(0, 1) == 1) begin
            put_byte(CHAR_SPACE);
            put_byte(CHAR_COLON);
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 3))
                    0: put_byte(CHAR_SPACE);
                    1: put_byte(CHAR_COLON);
                    default: put_byte(pick_content());
                endcase
            end
        end
        repeat ($urandom_range(0, 2)) put_byte(pick_blank());
        if (kind == LINE_BROKEN) begin
            if (line_q.size() > 0) begin
                line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 1) == 1) begin
                return;
            end
        end
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                m_tready <= 1'b0;
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        line_kind_t kind;
        int         line_no;
        int         random_sent;
        int         pick;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty prefix, a leading space with an empty trailing part, a prefix-only
        // line with trimmed blanks, and stray LF and CR bytes ending in CR CR LF.
        line_q = {CHAR_COLON, CHAR_SPACE, 8'h71, CHAR_CR, CHAR_LF,
                  CHAR_SPACE, 8'h7A, CHAR_SPACE, CHAR_COLON, CHAR_CR, CHAR_LF,
                  CHAR_COLON, 8'hFF, 8'h00, CHAR_TAB, CHAR_SPACE, CHAR_CR, CHAR_LF,
                  8'h61, CHAR_LF, 8'h62, CHAR_CR, 8'h63, CHAR_CR, CHAR_CR, CHAR_LF};
        foreach (line_q[i]) send_byte(line_q[i]);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);

        line_no     = 0;
        random_sent = 0;
        while (random_sent < 185) begin
            pick = $urandom_range(0, 19);
            if (line_no == 0) begin
                kind = LINE_OVERFLOW;
            end else if (line_no == 1 || pick == 0) begin
                kind = LINE_MANY_PARAMS;
            end else if (pick <= 3) begin
                kind = LINE_NOISE;
            end else if (pick <= 6) begin
                kind = LINE_BROKEN;
            end else begin
                kind = LINE_FORMED;
            end
            no_idle = ($urandom_range(0, 3) == 0);
            build_line(kind);
            foreach (line_q[i]) send_byte(line_q[i]);
            random_sent += line_q.size();
            if (line_no == 0) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending_results != 0) @(negedge aclk);
            end
            line_no++;
        end

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (mismatch_total == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/lntok_pkg.sv
src/lntok_ram.sv
src/lntok_ctrl.sv
src/lntok_datapath.sv
src/irc_line_tokenizer_unit.sv
sim/irc_line_tokenizer_unit_checker.sv
sim/irc_line_tokenizer_unit_tb.sv
